// ----- rtl/euler_xyz_to_quaternion_defines.svh -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion assertion macros
// Shared assertion forms for the conversion pipeline.
// ---------------------------------------------------------------------------
`ifndef EULER_XYZ_TO_QUATERNION_DEFINES_SVH
`define EULER_XYZ_TO_QUATERNION_DEFINES_SVH

// implication under synchronous reset
`define E2Q_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under synchronous reset
`define E2Q_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/e2q_pkg.sv -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion package
// Fixed-point constants, arctangent table and cell data type.
// ---------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_FRAC_BITS = 12;

  localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [31:0] Q28_TWO_PI  = 32'sd1686629713;
  localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] Q30_GAIN    = 32'sd652032874;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               flip;
  } e2q_rot_t;

  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] r;
    case (i)
      0: r = 32'sd210828714;  1: r = 32'sd124459457;  2: r = 32'sd65760959;
      3: r = 32'sd33381290;   4: r = 32'sd16755422;   5: r = 32'sd8385879;
      6: r = 32'sd4193963;    7: r = 32'sd2097109;    8: r = 32'sd1048571;
      9: r = 32'sd524287;     10: r = 32'sd262144;    11: r = 32'sd131072;
      12: r = 32'sd65536;     13: r = 32'sd32768;     14: r = 32'sd16384;
      15: r = 32'sd8192;      16: r = 32'sd4096;      17: r = 32'sd2048;
      18: r = 32'sd1024;      19: r = 32'sd512;       20: r = 32'sd256;
      21: r = 32'sd128;       22: r = 32'sd64;        23: r = 32'sd32;
      24: r = 32'sd16;        25: r = 32'sd8;         26: r = 32'sd4;
      27: r = 32'sd2;         28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/e2q_if.sv -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion channels
// Valid/ready interfaces for angle words and quaternion words.
// ---------------------------------------------------------------------------
interface e2q_angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2q_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- rtl/e2q_reduce.sv -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion range reduction
// Two-stage half-angle fold into [-pi/2, pi/2] with a negate flag.
// ---------------------------------------------------------------------------
module e2q_reduce (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  angle,
  output e2q_pkg::e2q_rot_t   rot
);
  import e2q_pkg::*;

  logic signed [31:0] half;
  logic signed [31:0] rem;
  logic signed [31:0] wrapped;
  logic signed [31:0] folded_r;
  logic signed [31:0] z_red;
  logic               fl;

  assign half = 32'(signed'(angle)) <<< (27 - ANGLE_FRAC_BITS);

  // |half| < 2^31 so at most one 2*pi step truncates toward zero
  always_comb begin
    rem = half;
    if (half >= Q28_TWO_PI)
      rem = half - Q28_TWO_PI;
    else if (half <= -Q28_TWO_PI)
      rem = half + Q28_TWO_PI;
    if (rem > Q28_PI)
      wrapped = rem - Q28_TWO_PI;
    else if (rem < -Q28_PI)
      wrapped = rem + Q28_TWO_PI;
    else
      wrapped = rem;
  end

  always_ff @(posedge clk) begin
    if (en)
      folded_r <= wrapped;
  end

  always_comb begin
    z_red = folded_r;
    fl    = 1'b0;
    if (folded_r > Q28_HALF_PI) begin
      z_red = folded_r - Q28_PI;
      fl    = 1'b1;
    end else if (folded_r < -Q28_HALF_PI) begin
      z_red = folded_r + Q28_PI;
      fl    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot.x    <= 33'(Q30_GAIN);
      rot.y    <= '0;
      rot.z    <= z_red;
      rot.flip <= fl;
    end
  end
endmodule

// ----- rtl/e2q_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion CORDIC cell
// One rotation-mode micro-rotation at a fixed shift, registered.
// ---------------------------------------------------------------------------
module e2q_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::e2q_rot_t in_rot,
  output e2q_pkg::e2q_rot_t out_rot
);
  import e2q_pkg::*;

  localparam int SH = (SHIFT > 32) ? 32 : SHIFT;

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [31:0] a;

  assign xs = in_rot.x >>> SH;
  assign ys = in_rot.y >>> SH;
  assign a  = atan_q28(SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot.flip <= in_rot.flip;
      if (!in_rot.z[31]) begin
        out_rot.x <= in_rot.x - ys;
        out_rot.y <= in_rot.y + xs;
        out_rot.z <= in_rot.z - a;
      end else begin
        out_rot.x <= in_rot.x + ys;
        out_rot.y <= in_rot.y - xs;
        out_rot.z <= in_rot.z + a;
      end
    end
  end
endmodule

// ----- rtl/e2q_product.sv -----
// ---------------------------------------------------------------------------
// Euler-to-quaternion product
// Three registered stages (two multiply, then sum and round) forming the Hamilton product qz*qy*qx.
// ---------------------------------------------------------------------------
module e2q_product #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               en,
  input  e2q_pkg::e2q_rot_t  rx,
  input  e2q_pkg::e2q_rot_t  ry,
  input  e2q_pkg::e2q_rot_t  rz,
  output logic signed [15:0] qx,
  output logic signed [15:0] qy,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw
);
  import e2q_pkg::*;

  localparam int RS = 30 - OUT_FRAC_BITS;

  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b + (66'sd1 <<< 29);
    return 33'(p >>> 30);
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [34:0] v);
    logic signed [34:0] r;
    logic signed [34:0] one;
    one = 35'sd1 <<< OUT_FRAC_BITS;
    if (RS == 0)
      r = v;
    else
      r = (v + (35'sd1 <<< (RS - 1))) >>> RS;
    if (r > one)
      r = one;
    if (r < -one)
      r = -one;
    return r[15:0];
  endfunction

  logic signed [32:0] sx, cx, sy, cy, sz, cz;
  logic signed [32:0] sx1, cx1, czcy, szsy, czsy, szcy;
  logic signed [32:0] t0, t1, t2, t3, t4, t5, t6, t7;

  assign sx = rx.flip ? -rx.y : rx.y;
  assign cx = rx.flip ? -rx.x : rx.x;
  assign sy = ry.flip ? -ry.y : ry.y;
  assign cy = ry.flip ? -ry.x : ry.x;
  assign sz = rz.flip ? -rz.y : rz.y;
  assign cz = rz.flip ? -rz.x : rz.x;

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= sx;
      cx1  <= cx;
      czcy <= mulq(cz, cy);
      szsy <= mulq(sz, sy);
      czsy <= mulq(cz, sy);
      szcy <= mulq(sz, cy);
      t0 <= mulq(czcy, sx1);
      t1 <= mulq(szsy, cx1);
      t2 <= mulq(czsy, cx1);
      t3 <= mulq(szcy, sx1);
      t4 <= mulq(szcy, cx1);
      t5 <= mulq(czsy, sx1);
      t6 <= mulq(czcy, cx1);
      t7 <= mulq(szsy, sx1);
      qx <= to_out(35'(t0) - 35'(t1));
      qy <= to_out(35'(t2) + 35'(t3));
      qz <= to_out(35'(t4) - 35'(t5));
      qw <= to_out(35'(t6) + 35'(t7));
    end
  end
endmodule

// ----- rtl/euler_xyz_to_quaternion.sv -----
// Throughput: one word per cycle; the whole pipeline, one CORDIC cell per
// iteration, advances together whenever the output register is free or taken.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// ---------------------------------------------------------------------------
// Euler XYZ to quaternion
// Half-angle CORDIC chains per axis followed by the Hamilton product.
// ---------------------------------------------------------------------------
`include "euler_xyz_to_quaternion_defines.svh"

module euler_xyz_to_quaternion #(
  parameter int OUT_FRAC_BITS   = 14,
  parameter int TRIG_ITERATIONS = 16
) (
  input logic       clk,
  input logic       rst,
  e2q_angle_if.sink in_ch,
  e2q_quat_if.source out_ch
);
  import e2q_pkg::*;

  localparam int DEPTH = 2 + TRIG_ITERATIONS + 3;

  logic [DEPTH-1:0] vld;
  logic             en;

  e2q_rot_t chain [3][TRIG_ITERATIONS+1];
  logic signed [15:0] ang [3];

  assign ang[0] = in_ch.angle_x;
  assign ang[1] = in_ch.angle_y;
  assign ang[2] = in_ch.angle_z;

  assign en           = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst)
      vld <= '0;
    else if (en)
      vld <= {vld[DEPTH-2:0], in_ch.valid};
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    e2q_reduce u_red (
      .clk(clk), .en(en), .angle(ang[a]), .rot(chain[a][0])
    );
    for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
      e2q_cordic_cell #(.SHIFT(i)) u_cell (
        .clk(clk), .en(en), .in_rot(chain[a][i]), .out_rot(chain[a][i+1])
      );
    end
  end

  e2q_product #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_prod (
    .clk(clk), .en(en),
    .rx(chain[0][TRIG_ITERATIONS]), .ry(chain[1][TRIG_ITERATIONS]),
    .rz(chain[2][TRIG_ITERATIONS]),
    .qx(out_ch.quat_x), .qy(out_ch.quat_y), .qz(out_ch.quat_z), .qw(out_ch.quat_w)
  );

  `E2Q_ASSERT_IMP(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `E2Q_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld[0])
  `E2Q_ASSERT_NEXT(a_hold_on_stall, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// Euler XYZ to quaternion testbench
// Drives angle words through a valid/ready channel under random idling and
// checks each quaternion word against a CORDIC-based predictor or a typed expected word.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2q_pkg::*;

  localparam int ANGLE_FRAC = 12;
  localparam int OUT_FRAC   = 14;
  localparam int ITERS      = 16;
  localparam int LATENCY    = 2 + ITERS + 3;
  localparam int WATCHDOG   = 20000;
  localparam int N_RANDOM   = 700;

  typedef struct {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 typed;
    quat_t              q;
  } angle_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  e2q_angle_if in_ch ();
  e2q_quat_if  out_ch ();

  euler_xyz_to_quaternion u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  quat_t quat_queue[$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  bit    quiet_tail = 1'b0;
  bit    hold_off = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul30(longint a, longint b);
    return floor_sh(a * b + (longint'(1) <<< 29), 30);
  endfunction

  function automatic void half_trig(logic signed [15:0] raw, output longint s,
                                    output longint c);
    longint z, x, y, nx, a;
    bit     flip;
    z = longint'(raw) * (longint'(1) <<< (27 - ANGLE_FRAC));
    x = Q30_GAIN;
    y = 0;
    flip = 1'b0;
    z = z % longint'(Q28_TWO_PI);
    if (z > Q28_PI) z -= Q28_TWO_PI;
    else if (z < -longint'(Q28_PI)) z += Q28_TWO_PI;
    if (z > Q28_HALF_PI) begin
      z -= Q28_PI;
      flip = 1'b1;
    end else if (z < -longint'(Q28_HALF_PI)) begin
      z += Q28_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < ITERS; i++) begin
      a = (i < 32) ? longint'(atan_q28(i)) : 0;
      if (z >= 0) begin
        nx = x - floor_sh(y, i);
        y  = y + floor_sh(x, i);
        z  -= a;
      end else begin
        nx = x + floor_sh(y, i);
        y  = y - floor_sh(x, i);
        z  += a;
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint one, r;
    one = longint'(1) <<< OUT_FRAC;
    r = floor_sh(v + (longint'(1) <<< (29 - OUT_FRAC)), 30 - OUT_FRAC);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(logic signed [15:0] ax, logic signed [15:0] ay,
                                         logic signed [15:0] az);
    longint sx, cx, sy, cy, sz, cz, czcy, szsy, czsy, szcy;
    quat_t  q;
    half_trig(ax, sx, cx);
    half_trig(ay, sy, cy);
    half_trig(az, sz, cz);
    czcy = mul30(cz, cy);
    szsy = mul30(sz, sy);
    czsy = mul30(cz, sy);
    szcy = mul30(sz, cy);
    q.qx = to_q14(mul30(czcy, sx) - mul30(szsy, cx));
    q.qy = to_q14(mul30(czsy, cx) + mul30(szcy, sx));
    q.qz = to_q14(mul30(szcy, cx) - mul30(czsy, sx));
    q.qw = to_q14(mul30(czcy, cx) + mul30(szsy, sx));
    return q;
  endfunction

  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, bit typed, quat_t q, bit gaps);
    if (gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.angle_x <= ax;
    in_ch.angle_y <= ay;
    in_ch.angle_z <= az;
    quat_queue.push_back(typed ? q : predict_quat(ax, ay, az));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (quat_queue.size() != 0) @(negedge clk);
  endtask

  // sink side: random stall bursts, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < 200; n++) @(negedge clk);
        hold_off = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (quat_queue.size() == 0) begin
        $error("quaternion word with nothing expected");
        fail_count++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_ch.quat_x !== exp_q.qx) begin
          $error("quat_x expected %0d actual %0d", exp_q.qx, out_ch.quat_x);
          fail_count++;
        end
        if (out_ch.quat_y !== exp_q.qy) begin
          $error("quat_y expected %0d actual %0d", exp_q.qy, out_ch.quat_y);
          fail_count++;
        end
        if (out_ch.quat_z !== exp_q.qz) begin
          $error("quat_z expected %0d actual %0d", exp_q.qz, out_ch.quat_z);
          fail_count++;
        end
        if (out_ch.quat_w !== exp_q.qw) begin
          $error("quat_w expected %0d actual %0d", exp_q.qw, out_ch.quat_w);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("euler_xyz_to_quaternion verification failed");
      $finish;
    end
  end

  initial begin
    angle_row_t rows[$];
    angle_row_t r;
    quat_t      unit;
    logic signed [15:0] vals[6];
    unit.qx = 16'sd0;
    unit.qy = 16'sd0;
    unit.qz = 16'sd0;
    unit.qw = 16'sd16384;
    vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh3244};
    in_ch.valid   = 1'b0;
    in_ch.angle_x = '0;
    in_ch.angle_y = '0;
    in_ch.angle_z = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero angles give the identity quaternion
    r = '{ax: 16'sd0, ay: 16'sd0, az: 16'sd0, typed: 1'b1, q: unit};
    rows.push_back(r);
    for (int i = 0; i < 6; i++) begin
      rows.push_back('{ax: vals[i], ay: 16'sd0, az: 16'sd0, typed: 1'b0, q: unit});
      rows.push_back('{ax: 16'sd0, ay: vals[i], az: 16'sd0, typed: 1'b0, q: unit});
      rows.push_back('{ax: 16'sd0, ay: 16'sd0, az: vals[i], typed: 1'b0, q: unit});
    end
    rows.push_back('{ax: 16'sh7fff, ay: 16'sh7fff, az: 16'sh7fff, typed: 1'b0, q: unit});
    rows.push_back('{ax: 16'sh8000, ay: 16'sh8000, az: 16'sh8000, typed: 1'b0, q: unit});
    rows.push_back('{ax: 16'sh1922, ay: 16'she6de, az: 16'sh1922, typed: 1'b0, q: unit});
    foreach (rows[i]) send_angles(rows[i].ax, rows[i].ay, rows[i].az, rows[i].typed,
                                  rows[i].q, 1'b1);
    drain_results();

    // fill the pipeline against a stalled sink
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, unit, 1'b0);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) quiet_tail = 1'b1;
      case ($urandom_range(0, 3))
        0: send_angles(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, unit, 1'b1);
        1: send_angles(16'($urandom_range(0, 12868) - 6434),
                       16'($urandom_range(0, 12868) - 6434),
                       16'($urandom_range(0, 12868) - 6434), 1'b0, unit, 1'b1);
        2: send_angles(vals[$urandom_range(0, 5)], 16'($urandom), vals[$urandom_range(0, 5)],
                       1'b0, unit, 1'b1);
        default: send_angles(16'($urandom_range(0, 255) - 128),
                             16'($urandom_range(0, 255) - 128),
                             16'($urandom), 1'b0, unit, 1'b1);
      endcase
    end
    drain_results();
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0)
      $display("euler_xyz_to_quaternion verification clean");
    else
      $display("euler_xyz_to_quaternion verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_reduce.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_product.sv
rtl/euler_xyz_to_quaternion.sv
bench/tb.sv
